// ===== rtl/tlptw_pkg.sv =====
package tlptw_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int VA_W   = 32;
    localparam int PPN_W  = 20;
    localparam int LEN_W  = 4;
    localparam int TYPE_W = 2;
    localparam int KIND_W = 2;
    localparam int CODE_W = 3;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_TRANSLATE_ENABLE = 1'd0;
    localparam logic [IDX_W-1:0] REG_ROOT_TABLE_PAGE  = 1'd1;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

    localparam logic [CODE_W-1:0] FAULT_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] FAULT_CROSS_PAGE = 3'd1;
    localparam logic [CODE_W-1:0] FAULT_DIR_INVAL  = 3'd2;
    localparam logic [CODE_W-1:0] FAULT_DIR_NOPTR  = 3'd3;
    localparam logic [CODE_W-1:0] FAULT_PERMISSION = 3'd4;
    localparam logic [CODE_W-1:0] FAULT_BAD_TYPE   = 3'd5;
    localparam logic [CODE_W-1:0] FAULT_UNEXPECTED = 3'd6;

    localparam logic [TYPE_W-1:0] ACC_FETCH = 2'd0;
    localparam logic [TYPE_W-1:0] ACC_READ  = 2'd1;
    localparam logic [TYPE_W-1:0] ACC_WRITE = 2'd2;

    // pte permission masks: V=bit0, R=bit1, W=bit2, X=bit3
    localparam logic [3:0] NEED_FETCH = 4'h9;
    localparam logic [3:0] NEED_READ  = 4'h3;
    localparam logic [3:0] NEED_WRITE = 4'h7;
    localparam logic [3:0] DIR_POINTER = 4'h1;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_DIR,
        PHASE_PTE
    } t_phase;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_CROSS,
        CLS_WALK,
        CLS_RESP
    } t_cls;

    typedef struct packed {
        t_cls              cls;
        logic [VA_W-1:0]   va;
        logic [TYPE_W-1:0] acc_type;
        logic [VA_W-1:0]   data;
        logic [VA_W-1:0]   dir_addr;
    } t_qentry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstatus;

endpackage

// ===== rtl/tlptw_front.sv =====
module tlptw_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tlptw_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [tlptw_pkg::PPN_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [tlptw_pkg::VA_W-1:0]    i_virtual_addr,
    input  logic [tlptw_pkg::LEN_W-1:0]   i_access_len,
    input  logic [tlptw_pkg::TYPE_W-1:0]  i_access_type,
    input  logic [tlptw_pkg::VA_W-1:0]    i_read_data,
    input  tlptw_pkg::t_qstatus           i_qstatus,
    output logic                          o_push,
    output tlptw_pkg::t_qentry            o_entry
);

    logic                        r_translate_enable;
    logic [tlptw_pkg::PPN_W-1:0] r_root_table_page;
    logic [tlptw_pkg::VA_W-1:0]  last_byte;
    logic                        crosses;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_translate_enable <= 1'b0;
            r_root_table_page  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tlptw_pkg::REG_TRANSLATE_ENABLE: r_translate_enable <= i_cfg_data[0];
                tlptw_pkg::REG_ROOT_TABLE_PAGE:  r_root_table_page  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = i_qstatus.full;
    assign o_push  = i_valid && !i_qstatus.full;

    // last byte of the access, 32-bit wrap
    assign last_byte = i_virtual_addr
                     + {{(tlptw_pkg::VA_W-tlptw_pkg::LEN_W){1'b0}}, i_access_len}
                     - 32'd1;
    assign crosses = (i_virtual_addr[31:12] != last_byte[31:12]);

    always_comb begin
        o_entry.va       = i_virtual_addr;
        o_entry.acc_type = i_access_type;
        o_entry.data     = i_read_data;
        o_entry.dir_addr = {r_root_table_page, i_virtual_addr[31:22], 2'b00};
        if (i_opcode) begin
            o_entry.cls = tlptw_pkg::CLS_RESP;
        end else if (!r_translate_enable) begin
            o_entry.cls = tlptw_pkg::CLS_PASS;
        end else if (crosses) begin
            o_entry.cls = tlptw_pkg::CLS_CROSS;
        end else begin
            o_entry.cls = tlptw_pkg::CLS_WALK;
        end
    end

endmodule

// ===== rtl/tlptw_queue.sv =====
module tlptw_queue #(
    parameter int DEPTH = tlptw_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tlptw_pkg::t_qentry  i_entry,
    input  logic                i_pop,
    output tlptw_pkg::t_qentry  o_entry,
    output tlptw_pkg::t_qstatus o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tlptw_pkg::t_qentry r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tlptw_back.sv =====
module tlptw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlptw_pkg::t_qentry            i_entry,
    input  tlptw_pkg::t_qstatus           i_qstatus,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tlptw_pkg::KIND_W-1:0]  o_result_kind,
    output logic [tlptw_pkg::VA_W-1:0]    o_address,
    output logic [tlptw_pkg::CODE_W-1:0]  o_fault_code
);

    tlptw_pkg::t_phase             r_phase;
    tlptw_pkg::t_phase             n_phase;
    logic [tlptw_pkg::VA_W-1:0]    r_pending_vaddr;
    logic [tlptw_pkg::VA_W-1:0]    n_pending_vaddr;
    logic [tlptw_pkg::TYPE_W-1:0]  r_pending_type;
    logic [tlptw_pkg::TYPE_W-1:0]  n_pending_type;
    logic                          r_out_valid;
    logic [tlptw_pkg::KIND_W-1:0]  r_kind;
    logic [tlptw_pkg::KIND_W-1:0]  n_kind;
    logic [tlptw_pkg::VA_W-1:0]    r_addr;
    logic [tlptw_pkg::VA_W-1:0]    n_addr;
    logic [tlptw_pkg::CODE_W-1:0]  r_code;
    logic [tlptw_pkg::CODE_W-1:0]  n_code;
    logic [3:0]                    need;
    logic                          bad_type;

    // output register frees when empty or being taken
    assign o_pop = !i_qstatus.empty && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= tlptw_pkg::PHASE_IDLE;
            r_pending_vaddr <= '0;
            r_pending_type  <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase         <= n_phase;
                r_pending_vaddr <= n_pending_vaddr;
                r_pending_type  <= n_pending_type;
                r_out_valid     <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_addr <= n_addr;
            r_code <= n_code;
        end
    end

    always_comb begin
        need     = tlptw_pkg::NEED_FETCH;
        bad_type = 1'b0;
        case (r_pending_type)
            tlptw_pkg::ACC_FETCH: need = tlptw_pkg::NEED_FETCH;
            tlptw_pkg::ACC_READ:  need = tlptw_pkg::NEED_READ;
            tlptw_pkg::ACC_WRITE: need = tlptw_pkg::NEED_WRITE;
            default:              bad_type = 1'b1;
        endcase
    end

    always_comb begin
        n_phase         = r_phase;
        n_pending_vaddr = r_pending_vaddr;
        n_pending_type  = r_pending_type;
        n_kind          = tlptw_pkg::KIND_FAULT;
        n_addr          = '0;
        n_code          = tlptw_pkg::FAULT_UNEXPECTED;
        if (i_entry.cls != tlptw_pkg::CLS_RESP) begin
            // a request during a walk leaves the walk alone
            if (r_phase == tlptw_pkg::PHASE_IDLE) begin
                unique case (i_entry.cls)
                    tlptw_pkg::CLS_PASS: begin
                        n_kind = tlptw_pkg::KIND_DONE;
                        n_addr = i_entry.va;
                        n_code = tlptw_pkg::FAULT_NONE;
                    end
                    tlptw_pkg::CLS_CROSS: begin
                        n_code = tlptw_pkg::FAULT_CROSS_PAGE;
                    end
                    tlptw_pkg::CLS_WALK: begin
                        n_kind          = tlptw_pkg::KIND_READ;
                        n_addr          = i_entry.dir_addr;
                        n_code          = tlptw_pkg::FAULT_NONE;
                        n_phase         = tlptw_pkg::PHASE_DIR;
                        n_pending_vaddr = i_entry.va;
                        n_pending_type  = i_entry.acc_type;
                    end
                    default: ;
                endcase
            end
        end else begin
            unique case (r_phase)
                tlptw_pkg::PHASE_DIR: begin
                    n_phase = tlptw_pkg::PHASE_IDLE;
                    if (!i_entry.data[0]) begin
                        n_code = tlptw_pkg::FAULT_DIR_INVAL;
                    end else if (i_entry.data[3:0] != tlptw_pkg::DIR_POINTER) begin
                        n_code = tlptw_pkg::FAULT_DIR_NOPTR;
                    end else begin
                        n_phase = tlptw_pkg::PHASE_PTE;
                        n_kind  = tlptw_pkg::KIND_READ;
                        n_addr  = {i_entry.data[29:10], r_pending_vaddr[21:12], 2'b00};
                        n_code  = tlptw_pkg::FAULT_NONE;
                    end
                end
                tlptw_pkg::PHASE_PTE: begin
                    n_phase = tlptw_pkg::PHASE_IDLE;
                    if (bad_type) begin
                        n_code = tlptw_pkg::FAULT_BAD_TYPE;
                    end else if ((i_entry.data[3:0] & need) != need) begin
                        n_code = tlptw_pkg::FAULT_PERMISSION;
                    end else begin
                        n_kind = tlptw_pkg::KIND_DONE;
                        n_addr = {i_entry.data[29:10], r_pending_vaddr[11:0]};
                        n_code = tlptw_pkg::FAULT_NONE;
                    end
                end
                default: begin
                    n_phase = tlptw_pkg::PHASE_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_address     = r_addr;
    assign o_fault_code  = r_code;

endmodule

// ===== rtl/two_level_page_table_walker_top.sv =====
// Two-level page table walker, Sv32 style without superpages. Each input item
// (a translation request or a memory response) yields exactly one result item:
// a table word read request, a finished translation or a fault. One item is
// taken per clock cycle while stall is low. An accepted item is written into
// the queue, and from the queue head it goes through the back walk stage into
// the output register when that register is empty or being taken. The
// queue holds QUEUE_DEPTH items; stall rises only when it is full, which takes
// a stalled output. Configuration writes are always ready and are sampled by a
// request when it is accepted.
module two_level_page_table_walker_top #(
    parameter int QUEUE_DEPTH = tlptw_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tlptw_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [tlptw_pkg::PPN_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [tlptw_pkg::VA_W-1:0]    i_virtual_addr,
    input  logic [tlptw_pkg::LEN_W-1:0]   i_access_len,
    input  logic [tlptw_pkg::TYPE_W-1:0]  i_access_type,
    input  logic [tlptw_pkg::VA_W-1:0]    i_read_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tlptw_pkg::KIND_W-1:0]  o_result_kind,
    output logic [tlptw_pkg::VA_W-1:0]    o_address,
    output logic [tlptw_pkg::CODE_W-1:0]  o_fault_code
);

    tlptw_pkg::t_qstatus qstatus;
    tlptw_pkg::t_qentry  push_entry;
    tlptw_pkg::t_qentry  head_entry;
    logic                push;
    logic                pop;

    tlptw_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_virtual_addr (i_virtual_addr),
        .i_access_len   (i_access_len),
        .i_access_type  (i_access_type),
        .i_read_data    (i_read_data),
        .i_qstatus      (qstatus),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    tlptw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (qstatus)
    );

    tlptw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_qstatus     (qstatus),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_address     (o_address),
        .o_fault_code  (o_fault_code)
    );

endmodule

// ===== rtl/tlptw_checker.sv =====
module tlptw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [tlptw_pkg::KIND_W-1:0]  o_result_kind,
    input logic [tlptw_pkg::VA_W-1:0]    o_address,
    input logic [tlptw_pkg::CODE_W-1:0]  o_fault_code
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind)
            && $stable(o_address) && $stable(o_fault_code))
        else $error("stalled result item changed");

    a_fault_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == tlptw_pkg::KIND_FAULT |->
            o_address == '0 && o_fault_code != tlptw_pkg::FAULT_NONE
            && o_fault_code <= tlptw_pkg::FAULT_UNEXPECTED)
        else $error("fault item badly formed");

    a_nofault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != tlptw_pkg::KIND_FAULT |->
            o_fault_code == tlptw_pkg::FAULT_NONE
            && (o_result_kind == tlptw_pkg::KIND_READ
                || o_result_kind == tlptw_pkg::KIND_DONE))
        else $error("non-fault item carries a code or a bad kind");

    // table word reads are word aligned
    a_read_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == tlptw_pkg::KIND_READ |-> o_address[1:0] == 2'b00)
        else $error("unaligned table read");

endmodule

bind two_level_page_table_walker_top tlptw_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_kind (o_result_kind),
    .o_address     (o_address),
    .o_fault_code  (o_fault_code)
);

// ===== sim/tb_two_level_page_table_walker_top.sv =====
`timescale 1ns / 100ps

module tb_two_level_page_table_walker_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEG_ITEMS = 330;
    localparam logic [tlptw_pkg::TYPE_W-1:0] ACC_INVALID = 2'd3;

    typedef struct packed {
        logic [tlptw_pkg::KIND_W-1:0] kind;
        logic [tlptw_pkg::VA_W-1:0]   addr;
        logic [tlptw_pkg::CODE_W-1:0] code;
    } t_walk_result;

    // tracks the walker state and queues the translation results it must produce
    class t_walk_scoreboard;
        logic                         xlate_on;
        logic [tlptw_pkg::PPN_W-1:0]  root_page;
        tlptw_pkg::t_phase            phase;
        logic [tlptw_pkg::VA_W-1:0]   walk_va;
        logic [tlptw_pkg::TYPE_W-1:0] walk_type;
        t_walk_result                 pending_results[$];
        int                           errors;

        function new();
            xlate_on = 1'b0;
            root_page = '0;
            phase = tlptw_pkg::PHASE_IDLE;
            walk_va = '0;
            walk_type = '0;
            errors = 0;
        endfunction

        function void note_config(logic [tlptw_pkg::IDX_W-1:0] idx,
                                  logic [tlptw_pkg::PPN_W-1:0] data);
            if (idx == tlptw_pkg::REG_TRANSLATE_ENABLE) begin
                xlate_on = data[0];
            end else begin
                root_page = data;
            end
        endfunction

        function void note_item(logic op, logic [tlptw_pkg::VA_W-1:0] va,
                                logic [tlptw_pkg::LEN_W-1:0] len,
                                logic [tlptw_pkg::TYPE_W-1:0] acc,
                                logic [tlptw_pkg::VA_W-1:0] word);
            t_walk_result r;
            logic [tlptw_pkg::VA_W-1:0] last;
            logic [3:0] need;
            r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_UNEXPECTED};
            if (op == 1'b0) begin
                if (phase != tlptw_pkg::PHASE_IDLE) begin
                    r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_UNEXPECTED};
                end else if (!xlate_on) begin
                    r = '{tlptw_pkg::KIND_DONE, va, tlptw_pkg::FAULT_NONE};
                end else begin
                    last = va + {28'd0, len} - 32'd1;
                    if (va[31:12] != last[31:12]) begin
                        r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_CROSS_PAGE};
                    end else begin
                        r = '{tlptw_pkg::KIND_READ,
                              {root_page, 12'd0} + {20'd0, va[31:22], 2'b00},
                              tlptw_pkg::FAULT_NONE};
                        walk_va = va;
                        walk_type = acc;
                        phase = tlptw_pkg::PHASE_DIR;
                    end
                end
            end else begin
                case (phase)
                    tlptw_pkg::PHASE_DIR: begin
                        if (!word[0]) begin
                            r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_DIR_INVAL};
                            phase = tlptw_pkg::PHASE_IDLE;
                        end else if (word[3:0] != tlptw_pkg::DIR_POINTER) begin
                            r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_DIR_NOPTR};
                            phase = tlptw_pkg::PHASE_IDLE;
                        end else begin
                            // ppn shifted up a page, word bits above 29 are not used
                            r = '{tlptw_pkg::KIND_READ,
                                  {word[29:10], 12'd0} + {20'd0, walk_va[21:12], 2'b00},
                                  tlptw_pkg::FAULT_NONE};
                            phase = tlptw_pkg::PHASE_PTE;
                        end
                    end
                    tlptw_pkg::PHASE_PTE: begin
                        phase = tlptw_pkg::PHASE_IDLE;
                        need = 4'h0;
                        case (walk_type)
                            tlptw_pkg::ACC_FETCH: need = tlptw_pkg::NEED_FETCH;
                            tlptw_pkg::ACC_READ:  need = tlptw_pkg::NEED_READ;
                            tlptw_pkg::ACC_WRITE: need = tlptw_pkg::NEED_WRITE;
                            default:              need = 4'h0;
                        endcase
                        if (walk_type == ACC_INVALID) begin
                            r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_BAD_TYPE};
                        end else if ((word[3:0] & need) != need) begin
                            r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_PERMISSION};
                        end else begin
                            r = '{tlptw_pkg::KIND_DONE, {word[29:10], walk_va[11:0]},
                                  tlptw_pkg::FAULT_NONE};
                        end
                    end
                    default: begin
                        phase = tlptw_pkg::PHASE_IDLE;
                        r = '{tlptw_pkg::KIND_FAULT, '0, tlptw_pkg::FAULT_UNEXPECTED};
                    end
                endcase
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [tlptw_pkg::KIND_W-1:0] kind,
                                   logic [tlptw_pkg::VA_W-1:0] addr,
                                   logic [tlptw_pkg::CODE_W-1:0] code);
            t_walk_result r;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: result_kind %0d address %h fault_code %0d",
                       kind, addr, code);
                errors++;
            end else begin
                r = pending_results.pop_front();
                if (kind !== r.kind) begin
                    $error("result_kind expected %0d actual %0d", r.kind, kind);
                    errors++;
                end
                if (addr !== r.addr) begin
                    $error("address expected %h actual %h", r.addr, addr);
                    errors++;
                end
                if (code !== r.code) begin
                    $error("fault_code expected %0d actual %0d", r.code, code);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [tlptw_pkg::IDX_W-1:0]   i_cfg_index = '0;
    logic [tlptw_pkg::PPN_W-1:0]   i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_opcode = 1'b0;
    logic [tlptw_pkg::VA_W-1:0]    i_virtual_addr = '0;
    logic [tlptw_pkg::LEN_W-1:0]   i_access_len = '0;
    logic [tlptw_pkg::TYPE_W-1:0]  i_access_type = '0;
    logic [tlptw_pkg::VA_W-1:0]    i_read_data = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [tlptw_pkg::KIND_W-1:0]  o_result_kind;
    logic [tlptw_pkg::VA_W-1:0]    o_address;
    logic [tlptw_pkg::CODE_W-1:0]  o_fault_code;

    t_walk_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;

    two_level_page_table_walker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_virtual_addr (i_virtual_addr),
        .i_access_len   (i_access_len),
        .i_access_type  (i_access_type),
        .i_read_data    (i_read_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_address      (o_address),
        .o_fault_code   (o_fault_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.note_config(i_cfg_index, i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                sb.note_item(i_opcode, i_virtual_addr, i_access_len, i_access_type,
                             i_read_data);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_result_kind, o_address, o_fault_code);
            end
        end
    end

    task automatic send_item(input logic op, input logic [tlptw_pkg::VA_W-1:0] va,
                             input logic [tlptw_pkg::LEN_W-1:0] len,
                             input logic [tlptw_pkg::TYPE_W-1:0] acc,
                             input logic [tlptw_pkg::VA_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_virtual_addr <= va;
        i_access_len <= len;
        i_access_type <= acc;
        i_read_data <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_req(input logic [tlptw_pkg::VA_W-1:0] va,
                            input logic [tlptw_pkg::LEN_W-1:0] len,
                            input logic [tlptw_pkg::TYPE_W-1:0] acc);
        send_item(1'b0, va, len, acc, $urandom);
    endtask

    task automatic send_resp(input logic [tlptw_pkg::VA_W-1:0] word);
        send_item(1'b1, $urandom, 4'($urandom), 2'($urandom), word);
    endtask

    task automatic set_config(input logic en, input logic [tlptw_pkg::PPN_W-1:0] root);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tlptw_pkg::REG_TRANSLATE_ENABLE;
        i_cfg_data <= {19'($urandom), en};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tlptw_pkg::REG_ROOT_TABLE_PAGE;
        i_cfg_data <= root;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // mostly complete walks with random words, the rest loose items
    task automatic random_items(input int count);
        int sent;
        logic [tlptw_pkg::VA_W-1:0] va;
        logic [tlptw_pkg::VA_W-1:0] dir_word;
        logic [tlptw_pkg::VA_W-1:0] pte_word;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                va = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    va[11:0] = 12'hFFF - 12'($urandom_range(0, 6));
                end
                dir_word = $urandom;
                if ($urandom_range(0, 99) < 85) begin
                    dir_word[3:0] = tlptw_pkg::DIR_POINTER;
                end
                pte_word = $urandom;
                if ($urandom_range(0, 99) < 70) begin
                    pte_word[3:0] = 4'hF;
                end
                send_req(va, 4'($urandom_range(1, 8)), 2'($urandom_range(0, 3)));
                send_resp(dir_word);
                send_resp(pte_word);
                sent += 3;
            end else begin
                send_item(1'($urandom), $urandom, 4'($urandom), 2'($urandom), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        int seg;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 25;
        recv_idle = 52;

        // pass-through: type is ignored, a response while idle is unexpected
        set_config(1'b0, 20'h00000);
        send_req(32'h0000_0000, 4'd1, tlptw_pkg::ACC_FETCH);
        send_req(32'hFFFF_FFFF, 4'd15, ACC_INVALID);
        send_resp(32'hFFFF_FFFF);
        drain();

        set_config(1'b1, 20'hFFFFF);
        send_req(32'h0000_0FFF, 4'd1, tlptw_pkg::ACC_FETCH);
        send_resp(32'h0000_0000);
        send_req(32'hFFFF_F000, 4'd8, tlptw_pkg::ACC_READ);
        send_resp(32'h0000_000F);
        // page crossing, zero length at a page start, wrap past the top
        send_req(32'h0000_0FFC, 4'd8, tlptw_pkg::ACC_WRITE);
        send_req(32'h0000_1000, 4'd0, tlptw_pkg::ACC_READ);
        send_req(32'hFFFF_FFFF, 4'd2, tlptw_pkg::ACC_FETCH);
        send_req(32'hFFFF_FFFF, 4'd1, tlptw_pkg::ACC_FETCH);
        send_resp(32'hFFFF_FC01);
        send_resp(32'hFFFF_FFFF);
        send_req(32'h0040_0123, 4'd15, tlptw_pkg::ACC_WRITE);
        send_resp(32'h1234_5401);
        send_resp(32'h0000_0003);
        send_req(32'h1234_5678, 4'd4, ACC_INVALID);
        send_resp(32'h0000_0001);
        send_resp(32'h0000_000F);
        // request arriving mid-walk leaves the walk intact
        send_req(32'h8000_0000, 4'd4, tlptw_pkg::ACC_READ);
        send_req(32'h0000_0000, 4'd1, tlptw_pkg::ACC_FETCH);
        send_resp(32'h0000_0401);
        send_resp(32'h0000_0003);
        send_resp(32'h0000_0000);
        drain();

        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle = 25;
                    recv_idle = 52;
                end
                1: begin
                    send_idle = 52;
                    recv_idle = 25;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            case (seg)
                0: set_config(1'b1, 20'($urandom));
                1: set_config(1'b0, 20'h00000);
                2: set_config(1'b1, 20'hFFFFF);
                3: set_config(1'b1, 20'h00000);
                4: set_config(1'b1, 20'($urandom));
                default: set_config(1'b0, 20'hFFFFF);
            endcase
            if (seg == 4) begin
                hold_req <= hold_req + 1;
            end
            random_items(SEG_ITEMS);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
